// ===== rtl/core/rar_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int NUM_BITS     = 2 * OPERAND_BITS + 1;
  localparam int DEN_BITS     = 2 * OPERAND_BITS;
  // internal arithmetic width, capped at 64 (wraps like XW-bit math)
  localparam int XW           = (NUM_BITS > 64) ? 64 : NUM_BITS;
  localparam int CNT_BITS     = $clog2(XW);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rar_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_RSVD     = 2'd3
  } rar_status_t;

  typedef struct packed {
    logic [1:0]                     opcode;
    logic signed [OPERAND_BITS-1:0] num_a;
    logic signed [OPERAND_BITS-1:0] den_a;
    logic signed [OPERAND_BITS-1:0] num_b;
    logic signed [OPERAND_BITS-1:0] den_b;
  } rar_in_t;

  typedef struct packed {
    logic signed [NUM_BITS-1:0] res_num;
    logic signed [DEN_BITS-1:0] res_den;
    logic [1:0]                 status;
  } rar_out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_A,
    CMD_MUL_B,
    CMD_ADD,
    CMD_MUL_D,
    CMD_GCD_GO,
    CMD_GCD_STEP,
    CMD_DIVN_GO,
    CMD_DIVN_SET,
    CMD_DIVD_SET,
    CMD_OUT
  } rar_cmd_t;

  typedef struct packed {
    logic err;
    logic addsub;
    logic b_zero;
    logic div_done;
    logic out_free;
  } rar_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/rar_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Signed truncating divider, one quotient bit per cycle.
module rar_div import rar_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [XW-1:0] dvd,
  input  wire logic signed [XW-1:0] dvs,
  output logic                      busy,
  output logic                      done,
  output logic signed [XW-1:0]      quot,
  output logic signed [XW-1:0]      rem
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0]       q_r, q_nxt;
  logic [XW-1:0]       r_r, r_nxt;
  logic [XW-1:0]       d_r, d_nxt;
  logic                nq_r, nq_nxt;
  logic                nr_r, nr_nxt;
  logic [XW:0]         rem_w;
  logic [XW:0]         diff;

  assign rem_w = {r_r, q_r[XW-1]};
  assign diff  = rem_w - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    nq_nxt   = nq_r;
    nr_nxt   = nr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dvd[XW-1] ? -dvd : dvd;
      d_nxt    = dvs[XW-1] ? -dvs : dvs;
      r_nxt    = '0;
      nq_nxt   = dvd[XW-1] ^ dvs[XW-1];
      nr_nxt   = dvd[XW-1];
    end else if (busy_r) begin
      q_nxt   = {q_r[XW-2:0], ~diff[XW]};
      r_nxt   = diff[XW] ? rem_w[XW-1:0] : diff[XW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_BITS'(XW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    nq_r  <= nq_nxt;
    nr_r  <= nr_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = nq_r ? -q_r : q_r;
  assign rem  = nr_r ? -r_r : r_r;

endmodule

`default_nettype wire

// ===== rtl/core/rar_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rar_dp import rar_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rar_cmd_t cmd,
  input  wire rar_in_t  in_data,
  input  wire logic     out_stall,
  output rar_sts_t      sts,
  output logic          out_valid,
  output rar_out_t      out_data
);

  localparam int OB = OPERAND_BITS;

  rar_in_t               in_r;
  logic [1:0]            st_r, st_nxt;
  logic signed [XW-1:0]  n_r, p_r, d_r, a_r, b_r;
  logic                  out_valid_r;
  rar_out_t              out_r;

  logic signed [OB:0]    mx;
  logic signed [OB-1:0]  my;
  logic signed [2*OB:0]  prod;
  logic signed [XW-1:0]  prod_x;

  logic                  div_start, div_busy, div_done;
  logic signed [XW-1:0]  div_dvd, div_dvs, div_q, div_rem;

  // status of a fresh item
  always_comb begin
    st_nxt = ST_OK;
    if (in_data.den_a == '0 || in_data.den_b == '0) begin
      st_nxt = ST_ZERO_DEN;
    end else if (in_data.opcode == OP_DIV && in_data.num_b == '0) begin
      st_nxt = ST_DIV_ZERO;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mx = (OB+1)'(in_r.den_a);
    my = in_r.den_b;
    case (cmd)
      CMD_MUL_A: begin
        mx = (OB+1)'(in_r.num_a);
        my = (in_r.opcode == OP_MUL) ? in_r.num_b : in_r.den_b;
      end
      CMD_MUL_B: begin
        mx = (in_r.opcode == OP_SUB) ? -((OB+1)'(in_r.num_b)) : (OB+1)'(in_r.num_b);
        my = in_r.den_a;
      end
      default: begin
        mx = (OB+1)'(in_r.den_a);
        my = (in_r.opcode == OP_DIV) ? in_r.num_b : in_r.den_b;
      end
    endcase
  end

  assign prod   = mx * my;
  assign prod_x = prod[XW-1:0];

  always_comb begin
    div_start = 1'b0;
    div_dvd   = a_r;
    div_dvs   = b_r;
    case (cmd)
      CMD_GCD_GO: begin
        div_start = 1'b1;
      end
      CMD_DIVN_GO: begin
        div_start = 1'b1;
        div_dvd   = n_r;
        div_dvs   = a_r;
      end
      CMD_DIVN_SET: begin
        div_start = 1'b1;
        div_dvd   = d_r;
        div_dvs   = a_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        in_r <= in_data;
        st_r <= st_nxt;
      end
      CMD_MUL_A:    n_r <= prod_x;
      CMD_MUL_B:    p_r <= prod_x;
      CMD_ADD:      n_r <= n_r + p_r;
      CMD_MUL_D: begin
        d_r <= prod_x;
        b_r <= prod_x;
        a_r <= n_r;
      end
      CMD_GCD_STEP: begin
        a_r <= b_r;
        b_r <= div_rem;
      end
      CMD_DIVN_SET: n_r <= div_q;
      CMD_DIVD_SET: d_r <= div_q;
      CMD_OUT: begin
        if (st_r != ST_OK) begin
          out_r.res_num <= '0;
          out_r.res_den <= '0;
        end else begin
          out_r.res_num <= NUM_BITS'($unsigned(n_r));
          out_r.res_den <= d_r[DEN_BITS-1:0];
        end
        out_r.status <= st_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.err      = (st_r != ST_OK);
  assign sts.addsub   = (in_r.opcode == OP_ADD) || (in_r.opcode == OP_SUB);
  assign sts.b_zero   = (b_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_OUT) |=> out_valid_r) else $error("result beat not posted");
  a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_GCD_STEP || cmd == CMD_DIVN_SET || cmd == CMD_DIVD_SET) |-> div_done)
    else $error("divider result taken early");

endmodule

`default_nettype wire

// ===== rtl/core/rar_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rar_ctrl import rar_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire rar_sts_t sts,
  output logic          in_stall,
  output rar_cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MUL_A  = 10'b00_0000_0010,
    S_MUL_B  = 10'b00_0000_0100,
    S_ADD    = 10'b00_0000_1000,
    S_MUL_D  = 10'b00_0001_0000,
    S_GCD    = 10'b00_0010_0000,
    S_GCD_W  = 10'b00_0100_0000,
    S_DIVN_W = 10'b00_1000_0000,
    S_DIVD_W = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } rar_state_t;

  rar_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_MUL_A;
        end
      end
      S_MUL_A: begin
        if (sts.err) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_MUL_A;
          state_nxt = sts.addsub ? S_MUL_B : S_MUL_D;
        end
      end
      S_MUL_B: begin
        cmd       = CMD_MUL_B;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd       = CMD_ADD;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        cmd       = CMD_MUL_D;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (sts.b_zero) begin
          cmd       = CMD_DIVN_GO;
          state_nxt = S_DIVN_W;
        end else begin
          cmd       = CMD_GCD_GO;
          state_nxt = S_GCD_W;
        end
      end
      S_GCD_W: begin
        if (sts.div_done) begin
          cmd       = CMD_GCD_STEP;
          state_nxt = S_GCD;
        end
      end
      S_DIVN_W: begin
        if (sts.div_done) begin
          cmd       = CMD_DIVN_SET;
          state_nxt = S_DIVD_W;
        end
      end
      S_DIVD_W: begin
        if (sts.div_done) begin
          cmd       = CMD_DIVD_SET;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd       = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/rational_arith_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | ports                          | beat
// --------+--------------------------------+----------------------------------
// input   | in_valid, in_stall, in_data    | opcode and two signed fractions
// result  | out_valid, out_stall, out_data | reduced fraction and status
//
// One item at a time. Setup runs on a single shared multiplier: MUL_A and
// MUL_D for mul/div, with MUL_B and ADD between them for add/sub. Each Euclid
// remainder and each of the two final divisions runs on one serial divider
// (XW = 2*OPERAND_BITS+1, capped at 64); the Euclid loop takes at most
// about 47 remainder steps (<= ~47).
// Errors skip the arithmetic and go from MUL_A straight to the final state.
// Synchronous active-low reset clears the controller, the divider's busy and done flags and the result valid.
// The result sits in an output register; a stalled result holds while the
// next item is accepted, which then waits in its final state for the slot.

module rational_arith_reduce import rar_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire rar_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output rar_out_t     out_data
);

  rar_cmd_t cmd;
  rar_sts_t sts;

  // sequencer: multiplies, Euclid loop, final divisions, output handoff
  rar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // operand registers, multiplier, serial divider and output register
  rar_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Testbench for rational_arith_reduce.
// Each accepted beat on the input channel is run through a local model of
// the fraction arithmetic and the signed Euclid reduction. The expected
// result is queued, and a monitor compares every result beat with the
// oldest queued entry, field by field.

module testbench;
  import rar_pkg::*;

  localparam int MAX_CYCLES = 5000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rar_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rar_out_t out_data;

  rar_out_t fraction_q[$];
  int       err_count;
  int       cycle_count;
  bit       stall_on;

  rational_arith_reduce dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Truncating remainder, with a zero or -1 divisor giving zero.
  function automatic longint trunc_rem(longint a, longint b);
    if (b == 0 || b == -1) return 0;
    return a % b;
  endfunction

  function automatic longint trunc_div(longint a, longint b);
    if (b == 0) return 0;
    if (b == -1) return -a;
    return a / b;
  endfunction

  // Expected reduced fraction for one input beat.
  function automatic rar_out_t model_reduce(rar_in_t b);
    rar_out_t r;
    longint na, da, nb, db, n, d, g, x, y, t;
    na = longint'(b.num_a);
    da = longint'(b.den_a);
    nb = longint'(b.num_b);
    db = longint'(b.den_b);
    r = '0;
    if (da == 0 || db == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    if (rar_op_t'(b.opcode) == OP_DIV && nb == 0) begin
      r.status = ST_DIV_ZERO;
      return r;
    end
    case (rar_op_t'(b.opcode))
      OP_ADD: begin
        n = na * db + nb * da;
        d = da * db;
      end
      OP_SUB: begin
        n = na * db - nb * da;
        d = da * db;
      end
      OP_MUL: begin
        n = na * nb;
        d = da * db;
      end
      default: begin
        n = na * db;
        d = da * nb;
      end
    endcase
    x = n;
    y = d;
    while (y != 0) begin
      t = trunc_rem(x, y);
      x = y;
      y = t;
    end
    g = x;
    if (g != 0) begin
      n = trunc_div(n, g);
      d = trunc_div(d, g);
    end
    r.res_num = n[NUM_BITS-1:0];
    r.res_den = d[DEN_BITS-1:0];
    r.status  = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // Mostly short gaps, sometimes a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  // Predict at the accepting edge, then lower valid after it.
  task automatic send_fraction(input rar_in_t b, input bit idle);
    int gap;
    gap = idle ? gap_len() : 0;
    repeat (gap + 1) @(negedge clk);
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    fraction_q.push_back(model_reduce(b));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Result monitor: sampled on the rising edge.
  always @(posedge clk) begin
    rar_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fraction_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = fraction_q.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.res_num !== want.res_num)
          report_mismatch("res_num", longint'(out_data.res_num), longint'(want.res_num));
        if (out_data.res_den !== want.res_den)
          report_mismatch("res_den", longint'(out_data.res_den), longint'(want.res_den));
      end
    end
  end

  // Receiver stall, in bursts; off during quiet stretches.
  always @(negedge clk) begin
    if (!stall_on) out_stall <= 1'b0;
    else if ($urandom_range(0, 39) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) == 0) out_stall <= 1'b0;
    else if (!out_stall && $urandom_range(0, 5) == 0) out_stall <= 1'b1;
  end

  function automatic rar_in_t mk(rar_op_t op, int na, int da, int nb, int db);
    rar_in_t b;
    b.opcode = op;
    b.num_a  = na[15:0];
    b.den_a  = da[15:0];
    b.num_b  = nb[15:0];
    b.den_b  = db[15:0];
    return b;
  endfunction

  task automatic wait_drained();
    while (fraction_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_fraction(mk(OP_ADD, 1, 2, 1, 3), 0);
    send_fraction(mk(OP_SUB, 1, 2, 1, 2), 0);
    send_fraction(mk(OP_MUL, -3, 4, 2, -9), 1);
    send_fraction(mk(OP_DIV, 5, 7, -10, 21), 1);
    send_fraction(mk(OP_ADD, 1, 0, 1, 1), 0);
    send_fraction(mk(OP_DIV, 1, 1, 2, 0), 0);
    send_fraction(mk(OP_DIV, 3, 4, 0, 5), 0);
    send_fraction(mk(OP_MUL, 0, -7, 5, 3), 0);
    send_fraction(mk(OP_ADD, -32768, -32768, -32768, -32768), 0);
    send_fraction(mk(OP_SUB, -32768, 32767, 32767, -32768), 0);
    send_fraction(mk(OP_MUL, 32767, 32767, -32768, 1), 1);
    send_fraction(mk(OP_DIV, -32768, 1, -32768, 32767), 1);
    send_fraction(mk(OP_ADD, -1, -1, -1, -1), 0);
    send_fraction(mk(OP_SUB, 32767, -1, -32768, 1), 0);
    send_fraction(mk(OP_DIV, 0, 3, 7, 2), 0);
    send_fraction(mk(OP_MUL, 6, 0, 0, 0), 0);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'(-32768 + $urandom_range(0, 2));
      1: return 16'(32767 - $urandom_range(0, 2));
      2: return 16'(int'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_random(input int count, input bit idle);
    rar_in_t b;
    repeat (count) begin
      b.opcode = 2'($urandom_range(0, 3));
      b.num_a  = rand_field();
      b.den_a  = rand_field();
      b.num_b  = rand_field();
      b.den_b  = rand_field();
      send_fraction(b, idle);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    stall_on = 1'b0;
    err_count = 0;
    cycle_count = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    stall_on = 1'b1;
    test_random(150, 1);
    // sender holds off until everything is back
    wait_drained();
    stall_on = 1'b0;
    test_random(50, 0);
    stall_on = 1'b1;
    test_random(130, 1);

    wait_drained();
    repeat (100) @(negedge clk);
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rar_pkg.sv
rtl/core/rar_div.sv
rtl/core/rar_dp.sv
rtl/core/rar_ctrl.sv
rtl/core/rational_arith_reduce.sv
tb/testbench.sv
